FILE: sv/quaternion_to_euler_angles_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for quaternion_to_euler_angles
// Shared same-cycle and next-cycle implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define Q2E_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define Q2E_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared constants, the arctangent table and pipeline types.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned AtanTabLen      = 24;
  // Width of the atan2 operands and of the CORDIC datapath.
  localparam int unsigned VecW            = 34;
  localparam int unsigned CorW            = 37;
  // Angle accumulator in Q.30 radians.
  localparam int unsigned AngW            = 35;
  // Square root: radicand up to 2^56, root up to 2^28.
  localparam int unsigned SqrtInW         = 57;
  localparam int unsigned SqrtOutW        = 29;

  localparam logic signed [AngW-1:0] PiQ30     = 35'sd3373259426;
  localparam logic signed [15:0]     PiQ13     = 16'sd25736;
  localparam logic signed [15:0]     HalfPiQ13 = 16'sd12868;

  // atan(2^-i) in Q.30, truncated.
  function automatic logic [31:0] atan_entry(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // Operands and flags that travel beside the square root.
  typedef struct packed {
    logic signed [VecW-1:0] roll_y;
    logic signed [VecW-1:0] roll_x;
    logic signed [VecW-1:0] yaw_y;
    logic signed [VecW-1:0] yaw_x;
    logic signed [28:0]     pitch_s;
    logic                   sat_pos;
    logic                   sat_neg;
  } side_t;

endpackage

FILE: sv/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Unit quaternion (Q1.14) to roll, pitch and yaw (Q2.13 radians), ZYX order.
// ----------------------------------------------------------------------------
// Channel  Dir  Width  Contents
// s_axis   in   64     quat_w, quat_x, quat_y, quat_z
// m_axis   out  48     roll_angle, pitch_angle, yaw_angle
//
// One request is taken per cycle while the output is not held. The stages are
// 4 product/sum stages, 29 square-root stages, the CORDIC pre-turn and
// rotations, and one rounding stage. The square root for pitch sets the depth.
// Reset clears only the valid bits. When the output is held, the whole
// pipeline holds; no request is dropped or repeated.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
  parameter int unsigned CORDIC_STAGES = q2e_pkg::CordicStagesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // roll_angle, pitch_angle, yaw_angle, pad
);

  localparam int unsigned VecW  = q2e_pkg::VecW;
  localparam int unsigned AngW  = q2e_pkg::AngW;
  localparam int unsigned SqN   = q2e_pkg::SqrtOutW;
  localparam int unsigned CordN = (CORDIC_STAGES < q2e_pkg::AtanTabLen) ?
                                  CORDIC_STAGES : q2e_pkg::AtanTabLen;
  localparam int unsigned Lat   = 4 + SqN + CordN + 1 + 1;

  logic           adv;
  logic [Lat-1:0] vld_q;

  // The whole pipeline moves unless a finished result is held.
  assign adv           = !vld_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  // Stage 1: all component products.
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;

  assign qw = $signed(s_axis_tdata[15:0]);
  assign qx = $signed(s_axis_tdata[31:16]);
  assign qy = $signed(s_axis_tdata[47:32]);
  assign qz = $signed(s_axis_tdata[63:48]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wx_q <= qw * qx;
      yz_q <= qy * qz;
      xx_q <= qx * qx;
      yy_q <= qy * qy;
      wz_q <= qw * qz;
      xy_q <= qx * qy;
      zz_q <= qz * qz;
      wy_q <= qw * qy;
      zx_q <= qz * qx;
    end
  end

  // Stage 2: atan2 operands and the pitch sine term.
  localparam logic signed [VecW-1:0] OneQ28 = VecW'(1) <<< 28;
  logic signed [VecW-1:0] roll_y_q, roll_x_q, yaw_y_q, yaw_x_q, s_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      roll_y_q <= (VecW'(wx_q) + VecW'(yz_q)) <<< 1;
      roll_x_q <= OneQ28 - ((VecW'(xx_q) + VecW'(yy_q)) <<< 1);
      yaw_y_q  <= (VecW'(wz_q) + VecW'(xy_q)) <<< 1;
      yaw_x_q  <= OneQ28 - ((VecW'(yy_q) + VecW'(zz_q)) <<< 1);
      s_q      <= (VecW'(wy_q) - VecW'(zx_q)) <<< 1;
    end
  end

  // Stage 3: saturation flags and the square of the sine term.
  logic [27:0]           s_mag;
  logic [55:0]           sq_q;
  q2e_pkg::side_t        p3_q;

  assign s_mag = s_q[28] ? 28'(-s_q) : s_q[27:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q         <= s_mag * s_mag;
      p3_q.roll_y  <= roll_y_q;
      p3_q.roll_x  <= roll_x_q;
      p3_q.yaw_y   <= yaw_y_q;
      p3_q.yaw_x   <= yaw_x_q;
      p3_q.pitch_s <= s_q[28:0];
      p3_q.sat_pos <= (s_q >= OneQ28);
      p3_q.sat_neg <= (s_q <= -OneQ28);
    end
  end

  // Stage 4: radicand for the cosine, 1 - s^2 in Q.56.
  logic [q2e_pkg::SqrtInW-1:0] rad_q;
  q2e_pkg::side_t              p4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad_q <= (q2e_pkg::SqrtInW'(1) << 56) - q2e_pkg::SqrtInW'(sq_q);
      p4_q  <= p3_q;
    end
  end

  // Square root, with the other operands delayed alongside.
  logic [SqN-1:0] root;
  q2e_pkg::side_t side_dl_q [SqN];

  q2e_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rad_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_dl_q[0] <= p4_q;
      for (int k = 1; k < SqN; k++) begin
        side_dl_q[k] <= side_dl_q[k-1];
      end
    end
  end

  // Three CORDIC pipelines in parallel.
  q2e_pkg::side_t         sd;
  logic signed [AngW-1:0] roll_ang, pitch_ang, yaw_ang;
  logic [1:0]             sat_dl_q [CordN+1];

  assign sd = side_dl_q[SqN-1];

  q2e_cordic #(.CordicStages(CORDIC_STAGES)) u_roll (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (sd.roll_y),
    .x_i   (sd.roll_x),
    .ang_o (roll_ang)
  );

  q2e_cordic #(.CordicStages(CORDIC_STAGES)) u_pitch (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (VecW'($signed(sd.pitch_s))),
    .x_i   ($signed(VecW'(root))),
    .ang_o (pitch_ang)
  );

  q2e_cordic #(.CordicStages(CORDIC_STAGES)) u_yaw (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (sd.yaw_y),
    .x_i   (sd.yaw_x),
    .ang_o (yaw_ang)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sat_dl_q[0] <= {sd.sat_pos, sd.sat_neg};
      for (int k = 1; k <= CordN; k++) begin
        sat_dl_q[k] <= sat_dl_q[k-1];
      end
    end
  end

  // Final stage: round to Q2.13, clamp, and apply pitch saturation.
  localparam logic signed [AngW-1:0] Half  = AngW'(1) <<< 16;
  localparam logic signed [AngW-1:0] PiL   = AngW'(q2e_pkg::PiQ13);
  localparam logic signed [AngW-1:0] HpiL  = AngW'(q2e_pkg::HalfPiQ13);

  logic signed [AngW-1:0] roll_r, pitch_r, yaw_r;
  logic signed [15:0]     roll_c, yaw_c;
  logic signed [14:0]     pitch_c;
  logic                   sat_p, sat_n;
  logic signed [15:0]     roll_q, yaw_q;
  logic signed [14:0]     pitch_q;

  assign sat_p = sat_dl_q[CordN][1];
  assign sat_n = sat_dl_q[CordN][0];

  always_comb begin
    roll_r  = (roll_ang + Half) >>> 17;
    pitch_r = (pitch_ang + Half) >>> 17;
    yaw_r   = (yaw_ang + Half) >>> 17;

    if (roll_r > PiL)        roll_c = q2e_pkg::PiQ13;
    else if (roll_r < -PiL)  roll_c = -q2e_pkg::PiQ13;
    else                     roll_c = roll_r[15:0];

    if (yaw_r > PiL)         yaw_c = q2e_pkg::PiQ13;
    else if (yaw_r < -PiL)   yaw_c = -q2e_pkg::PiQ13;
    else                     yaw_c = yaw_r[15:0];

    if (sat_p)               pitch_c = q2e_pkg::HalfPiQ13[14:0];
    else if (sat_n)          pitch_c = 15'(-q2e_pkg::HalfPiQ13);
    else if (pitch_r > HpiL) pitch_c = q2e_pkg::HalfPiQ13[14:0];
    else if (pitch_r < -HpiL) pitch_c = 15'(-q2e_pkg::HalfPiQ13);
    else                     pitch_c = pitch_r[14:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      roll_q  <= roll_c;
      pitch_q <= pitch_c;
      yaw_q   <= yaw_c;
    end
  end

  assign m_axis_tdata = {1'b0, yaw_q, pitch_q, roll_q};

  // Checks on pipeline control and result ranges.
  `include "quaternion_to_euler_angles_assert.svh"

  `Q2E_ASSERT_NEXT(a_hold_valid, !adv, $stable(vld_q), "valid bits moved during a stall")
  `Q2E_ASSERT_NEXT(a_pitch_sat, adv && vld_q[Lat-2] && sat_p, pitch_q == q2e_pkg::HalfPiQ13[14:0], "positive pitch saturation lost")
  `Q2E_ASSERT_SAME(a_roll_range, m_axis_tvalid, (roll_q <= q2e_pkg::PiQ13) && (roll_q >= -q2e_pkg::PiQ13), "roll out of range")
  `Q2E_ASSERT_SAME(a_sat_excl, vld_q[Lat-2], !(sat_p && sat_n), "both pitch saturation flags set")

endmodule

FILE: sv/q2e_isqrt.sv
// ----------------------------------------------------------------------------
// q2e_isqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module q2e_isqrt (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [q2e_pkg::SqrtInW-1:0]        rad_i,
  output logic [q2e_pkg::SqrtOutW-1:0]       root_o
);

  localparam int unsigned RemW = q2e_pkg::SqrtInW + 1;
  localparam int unsigned N    = q2e_pkg::SqrtOutW;

  logic [RemW-1:0] rem_q  [N];
  logic [N-1:0]    root_q [N];

  // Stage j decides root bit N-1-j by a trial subtraction.
  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int unsigned B = N - 1 - j;
    logic [RemW-1:0] rem_in;
    logic [N-1:0]    root_in;
    logic [RemW-1:0] trial;

    if (j == 0) begin : g_first
      assign rem_in  = RemW'(rad_i);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    assign trial = (RemW'(root_in) << (B + 1)) + (RemW'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[j]  <= rem_in - trial;
          root_q[j] <= root_in | (N'(1) << B);
        end else begin
          rem_q[j]  <= rem_in;
          root_q[j] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

FILE: sv/q2e_cordic.sv
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined vectoring CORDIC giving atan2(y, x) in Q.30 radians.
// ----------------------------------------------------------------------------
module q2e_cordic #(
  parameter int unsigned CordicStages = q2e_pkg::CordicStagesDef
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [q2e_pkg::VecW-1:0]      y_i,
  input  logic signed [q2e_pkg::VecW-1:0]      x_i,
  output logic signed [q2e_pkg::AngW-1:0]      ang_o
);

  localparam int unsigned N = (CordicStages < q2e_pkg::AtanTabLen) ?
                              CordicStages : q2e_pkg::AtanTabLen;
  localparam int unsigned CorW = q2e_pkg::CorW;
  localparam int unsigned AngW = q2e_pkg::AngW;

  logic signed [CorW-1:0] x_q [N+1];
  logic signed [CorW-1:0] y_q [N+1];
  logic signed [AngW-1:0] a_q [N+1];

  // A vector in the left half plane is turned by pi first.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (x_i < 0) begin
        x_q[0] <= -CorW'(x_i);
        y_q[0] <= -CorW'(y_i);
        a_q[0] <= (y_i >= 0) ? q2e_pkg::PiQ30 : -q2e_pkg::PiQ30;
      end else begin
        x_q[0] <= CorW'(x_i);
        y_q[0] <= CorW'(y_i);
        a_q[0] <= '0;
      end
    end
  end

  // One micro-rotation per stage, driving y toward zero.
  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [CorW-1:0] xs;
    logic signed [CorW-1:0] ys;
    logic signed [AngW-1:0] step;

    assign xs   = x_q[i] >>> i;
    assign ys   = y_q[i] >>> i;
    assign step = $signed(AngW'(q2e_pkg::atan_entry(i)));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          a_q[i+1] <= a_q[i] + step;
        end else if (y_q[i] < 0) begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          a_q[i+1] <= a_q[i] - step;
        end else begin
          x_q[i+1] <= x_q[i];
          y_q[i+1] <= y_q[i];
          a_q[i+1] <= a_q[i];
        end
      end
    end
  end

  assign ang_o = a_q[N];

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles testbench
// Sends directed and random quaternions with bursty traffic and a stalling
// receiver, predicts each angle triple, and compares the results in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int Stages   = 16;
  localparam longint PiQ30 = 64'sd3373259426;
  localparam longint OneQ28 = 64'sd1 << 28;

  // The first member of a packed struct sits in the highest bits, so w is
  // listed last to land in the lowest bits of the request.
  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic signed [15:0] w;
  } quat_t;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } euler_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // quat_w, quat_x, quat_y, quat_z
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // roll_angle, pitch_angle, yaw_angle, pad

  quat_t  quat_queue[$];
  euler_t angle_queue[$];
  int     fail_count = 0;
  logic   took;
  int     burst_left;
  int     gap_left;
  int     cyc;

  quaternion_to_euler_angles uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Arctangent of 2^-i in Q.30, truncated.
  function automatic longint atan_q30(int i);
    case (i)
      0:  return 64'h3243F6A8;
      1:  return 64'h1DAC6705;
      2:  return 64'h0FADBAFC;
      3:  return 64'h07F56EA6;
      4:  return 64'h03FEAB76;
      5:  return 64'h01FFD55B;
      6:  return 64'h00FFFAAA;
      7:  return 64'h007FFF55;
      8:  return 64'h003FFFEA;
      9:  return 64'h001FFFFD;
      10: return 64'h000FFFFF;
      11: return 64'h0007FFFF;
      12: return 64'h0003FFFF;
      13: return 64'h0001FFFF;
      14: return 64'h0000FFFF;
      15: return 64'h00007FFF;
      16: return 64'h00003FFF;
      17: return 64'h00001FFF;
      18: return 64'h00000FFF;
      19: return 64'h000007FF;
      20: return 64'h000003FF;
      21: return 64'h000001FF;
      22: return 64'h000000FF;
      default: return 64'h0000007F;
    endcase
  endfunction

  // Vectoring CORDIC arctangent, rounded to Q2.13 and clamped.
  function automatic longint cordic_angle(longint vy, longint vx, longint lim);
    longint acc;
    longint xs;
    longint ys;
    longint r;
    acc = 0;
    if (vx < 0) begin
      acc = (vy >= 0) ? PiQ30 : -PiQ30;
      vx = -vx;
      vy = -vy;
    end
    for (int i = 0; i < Stages && i < 24; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy > 0) begin
        vx += ys;
        vy -= xs;
        acc += atan_q30(i);
      end else if (vy < 0) begin
        vx -= ys;
        vy += xs;
        acc -= atan_q30(i);
      end
    end
    r = (acc + 65536) >>> 17;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  // Floor of the integer square root.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic euler_t predict_angles(quat_t q);
    longint w, x, y, z, s, c;
    euler_t e;
    w = q.w;
    x = q.x;
    y = q.y;
    z = q.z;
    e.roll = 16'(cordic_angle(2 * (w * x + y * z), OneQ28 - 2 * (x * x + y * y), 25736));
    s = 2 * (w * y - z * x);
    if (s >= OneQ28) begin
      e.pitch = 15'sd12868;
    end else if (s <= -OneQ28) begin
      e.pitch = -15'sd12868;
    end else begin
      c = longint'(int_sqrt((64'd1 << 56) - longint'(s * s)));
      e.pitch = 15'(cordic_angle(s, c, 12868));
    end
    e.yaw = 16'(cordic_angle(2 * (w * z + x * y), OneQ28 - 2 * (y * y + z * z), 25736));
    return e;
  endfunction

  function automatic quat_t make_quat(int w, int x, int y, int z);
    quat_t q;
    q.w = 16'(w);
    q.x = 16'(x);
    q.y = 16'(y);
    q.z = 16'(z);
    return q;
  endfunction

  // Random quaternion: mostly unit length, plus raw patterns and near gimbal lock.
  function automatic quat_t random_quat();
    real a, b, c, d, n;
    int  k;
    k = $urandom_range(0, 9);
    if (k <= 5) begin
      a = real'($urandom_range(0, 2000)) - 1000.0;
      b = real'($urandom_range(0, 2000)) - 1000.0;
      c = real'($urandom_range(0, 2000)) - 1000.0;
      d = real'($urandom_range(0, 2000)) - 1000.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n == 0.0) return make_quat(16384, 0, 0, 0);
      return make_quat($rtoi(a / n * 16384.0), $rtoi(b / n * 16384.0),
                       $rtoi(c / n * 16384.0), $rtoi(d / n * 16384.0));
    end else if (k == 6) begin
      return make_quat($urandom, $urandom, $urandom, $urandom);
    end else if (k == 7) begin
      return make_quat($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                       $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
    end else if (k == 8) begin
      // Pitch term close to plus or minus one.
      a = ($urandom_range(0, 1) != 0) ? 1.0 : -1.0;
      return make_quat(11585 + $urandom_range(0, 40) - 20,
                       $urandom_range(0, 40) - 20,
                       $rtoi(a * 11585.0) + $urandom_range(0, 40) - 20,
                       $urandom_range(0, 40) - 20);
    end else begin
      // Angle arguments with negative x and zero y.
      return make_quat(0, $urandom_range(0, 1) ? 16384 : -16384, 0, 0);
    end
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Reset and stimulus.
  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed quaternions.
    quat_queue.push_back(make_quat(0, 0, 0, 0));
    quat_queue.push_back(make_quat(16384, 0, 0, 0));
    quat_queue.push_back(make_quat(-16384, 0, 0, 0));
    quat_queue.push_back(make_quat(0, 16384, 0, 0));
    quat_queue.push_back(make_quat(0, 0, 16384, 0));
    quat_queue.push_back(make_quat(0, 0, 0, 16384));
    quat_queue.push_back(make_quat(0, -16384, 0, 0));
    quat_queue.push_back(make_quat(16384, 0, 16384, 0));
    quat_queue.push_back(make_quat(16384, 0, -16384, 0));
    quat_queue.push_back(make_quat(11585, 0, 11585, 0));
    quat_queue.push_back(make_quat(11585, 0, -11585, 0));
    quat_queue.push_back(make_quat(11585, 11585, 0, 0));
    quat_queue.push_back(make_quat(11585, 0, 0, -11585));
    quat_queue.push_back(make_quat(-32768, -32768, -32768, -32768));
    quat_queue.push_back(make_quat(32767, 32767, 32767, 32767));
    quat_queue.push_back(make_quat(-32768, 32767, -32768, 32767));
    quat_queue.push_back(make_quat(32767, -32768, 0, 0));
    quat_queue.push_back(make_quat(8192, 8192, 8192, 8192));
    quat_queue.push_back(make_quat(8192, -8192, 8192, -8192));
    quat_queue.push_back(make_quat(0, 0, -16384, 16384));
    for (int i = 0; i < 260; i++) quat_queue.push_back(random_quat());

    // Let the pipeline drain completely once.
    wait (quat_queue.size() == 0 && angle_queue.size() == 0 && !s_axis_tvalid);
    for (int i = 0; i < 280; i++) quat_queue.push_back(random_quat());

    wait (quat_queue.size() == 0 && !s_axis_tvalid && angle_queue.size() == 0);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  // Sender: bursts of requests with random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left <= 1;
      gap_left <= 0;
    end else if (!s_axis_tvalid || took) begin
      if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (quat_queue.size() > 0) begin
        s_axis_tdata <= quat_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern steps through four modes in turn.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      cyc <= 0;
      m_axis_tready <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      case ((cyc / 300) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) != 0);
        2: m_axis_tready <= ($urandom_range(0, 4) != 0);
        default: m_axis_tready <= ((cyc % 7) >= 3);
      endcase
    end
  end

  // Record accepted requests and check results against the oldest prediction.
  always @(posedge clk_i) begin
    euler_t exp_e;
    took <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      angle_queue.push_back(predict_angles(quat_t'(s_axis_tdata)));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (angle_queue.size() == 0) begin
        $error("result with no request pending: %h", m_axis_tdata);
        fail_count++;
      end else begin
        exp_e = angle_queue.pop_front();
        if (m_axis_tdata[15:0] !== exp_e.roll) begin
          $error("roll_angle expected %0d actual %0d", exp_e.roll,
                 $signed(m_axis_tdata[15:0]));
          fail_count++;
        end
        if (m_axis_tdata[30:16] !== exp_e.pitch) begin
          $error("pitch_angle expected %0d actual %0d", exp_e.pitch,
                 $signed(m_axis_tdata[30:16]));
          fail_count++;
        end
        if (m_axis_tdata[46:31] !== exp_e.yaw) begin
          $error("yaw_angle expected %0d actual %0d", exp_e.yaw,
                 $signed(m_axis_tdata[46:31]));
          fail_count++;
        end
      end
    end
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/q2e_pkg.sv
sv/q2e_isqrt.sv
sv/q2e_cordic.sv
sv/quaternion_to_euler_angles.sv
test/tb_top.sv
